// ----- hw/rtl/growable_array_insert_remove_core_assert.svh -----
// Assertion macros for the growable array core.
// Used by growable_array_insert_remove_core.sv; no other dependencies.
`ifndef GROWABLE_ARRAY_INSERT_REMOVE_CORE_ASSERT_SVH
`define GROWABLE_ARRAY_INSERT_REMOVE_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define GAI_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("growable array: invariant violated");

// Antecedent implies consequent in the same cycle
`define GAI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("growable array: implication violated");

`endif

// ----- hw/rtl/gai_pkg.sv -----
// Package for the growable array core: sizes, command and status codes,
// sequencer states and the capacity clamp. No dependencies.
package gai_pkg;

   localparam int DEPTH      = 16;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int ELEM_W     = 32;
   localparam int POS_W      = 6;
   localparam int CAP_CFG_W  = 7;
   localparam int SIZE_W     = 7;
   localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_PAD_W  = RSP_DATA_W - (2 + ELEM_W + POS_W + 2 * SIZE_W);
   localparam int INIT_CAP   = 3;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_SHOW   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_BADIDX = 2'd1,
      STS_FULL   = 2'd2,
      STS_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_STEP,
      ST_INS_WR,
      ST_REM_STEP,
      ST_REM_WR,
      ST_SHOW_RD,
      ST_SHOW_LD,
      ST_RESP
   } state_type;

   // Clamp a written capacity into 1..DEPTH
   function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_CFG_W-1:0] c);
      logic [CNT_W-1:0] r;
      if (c == '0) begin
         r = CNT_W'(1);
      end else if (int'(c) > DEPTH) begin
         r = CNT_W'(DEPTH);
      end else begin
         r = CNT_W'(c);
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/growable_array_insert_remove_core.sv -----
// Growable ordered store of signed 32-bit values with a doubling and halving
// logical capacity. Depends on gai_pkg and growable_array_insert_remove_core_assert.svh.
`include "growable_array_insert_remove_core_assert.svh"

// Ordered store of up to DEPTH (16) signed values in a single-port style
// memory (one write and one registered read per cycle), driven by a small
// sequencer. Requests carry cmd in req_tuser: append, insert, remove, show.
// One request is handled at a time; req_tready is high only when idle.
// Every shift step moves one entry by a read and then a write through
// the memory port. Show returns one response per element, rsp_tlast
// on the final one.
// Capacity is loaded from csr_wdata (clamped to 1..DEPTH, and raised to the
// current count if smaller) on csr_wen; write it only while idle.
module growable_array_insert_remove_core (
   input  logic                               clock,
   input  logic                               reset,
   // request: tuser = cmd[1:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: value[31:0], position[37:32], zero pad[39:38]
   input  logic [gai_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                         req_tuser,
   // response
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: status[1:0], element[33:2], element_index[39:34],
   //        size_now[46:40], capacity_now[53:47], zero pad[55:54]
   output logic [gai_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,
   // capacity register
   input  logic                               csr_wen,
   input  logic [gai_pkg::CAP_CFG_W-1:0]      csr_wdata
);
   import gai_pkg::*;

   state_type              state_ff, state_in;
   cmd_type                op_ff, op_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       capacity_ff, capacity_in;
   logic [CNT_W-1:0]       ptr_ff, ptr_in;
   logic [CNT_W-1:0]       pos_ff, pos_in;
   logic [ELEM_W-1:0]      value_ff, value_in;
   status_type             status_ff, status_in;
   logic [ELEM_W-1:0]      element_ff, element_in;
   logic [POS_W-1:0]       eidx_ff, eidx_in;
   logic                   last_ff, last_in;

   logic [ELEM_W-1:0]      mem [DEPTH];
   logic [ELEM_W-1:0]      rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [ELEM_W-1:0]      mem_wdata;

   cmd_type                req_cmd;
   logic [ELEM_W-1:0]      req_value;
   logic [CMP_W-1:0]       req_pos_w;
   logic [CMP_W-1:0]       count_w;
   logic                   req_acc;
   logic [CNT_W:0]         cap_dbl;
   logic [CNT_W-1:0]       cap_grow;
   logic [CNT_W-1:0]       ptr_inc;
   logic [CNT_W-1:0]       ptr_dec;
   logic [CNT_W-1:0]       cnt_dec;
   logic [CNT_W-1:0]       cap_half;
   logic [CNT_W-1:0]       cfg_cap;

   assign req_cmd   = cmd_type'(req_tuser);
   assign req_value = req_tdata[ELEM_W-1:0];
   assign req_pos_w = CMP_W'(req_tdata[ELEM_W +: POS_W]);
   assign count_w   = CMP_W'(count_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // Shared pointer and count arithmetic
   assign ptr_inc  = ptr_ff + CNT_W'(1);
   assign ptr_dec  = ptr_ff - CNT_W'(1);
   assign cnt_dec  = count_ff - CNT_W'(1);
   assign cap_half = capacity_ff >> 1;
   assign cap_dbl  = {capacity_ff, 1'b0};
   assign cap_grow = (count_ff < capacity_ff) ? capacity_ff :
                     (cap_dbl > (CNT_W + 1)'(DEPTH)) ? CNT_W'(DEPTH) :
                     cap_dbl[CNT_W-1:0];
   assign cfg_cap  = (clamp_cap(csr_wdata) < count_ff) ? count_ff : clamp_cap(csr_wdata);

   always_comb begin
      case (state_ff)
         ST_INS_STEP: rd_addr = ptr_dec[IDX_W-1:0];
         ST_REM_STEP: rd_addr = ptr_inc[IDX_W-1:0];
         default:     rd_addr = ptr_ff[IDX_W-1:0];
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_RESP;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (req_pos_w <= count_w && count_ff < capacity_ff
                         && int'(count_ff) < DEPTH) begin
                        state_in = ST_INS_STEP;
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff != '0 && req_pos_w < count_w) begin
                        state_in = ST_REM_STEP;
                     end
                  end
                  CMD_SHOW: begin
                     if (count_ff != '0) begin
                        state_in = ST_SHOW_RD;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_INS_STEP: state_in = (ptr_ff == pos_ff) ? ST_RESP : ST_INS_WR;
         ST_INS_WR:   state_in = ST_INS_STEP;
         ST_REM_STEP: state_in = (ptr_inc >= count_ff) ? ST_RESP : ST_REM_WR;
         ST_REM_WR:   state_in = ST_REM_STEP;
         ST_SHOW_RD:  state_in = ST_SHOW_LD;
         ST_SHOW_LD:  state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = (op_ff == CMD_SHOW && !last_ff) ? ST_SHOW_RD : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      op_in       = op_ff;
      count_in    = count_ff;
      capacity_in = capacity_ff;
      ptr_in      = ptr_ff;
      pos_in      = pos_ff;
      value_in    = value_ff;
      status_in   = status_ff;
      element_in  = element_ff;
      eidx_in     = eidx_ff;
      last_in     = last_ff;
      mem_we      = 1'b0;
      mem_waddr   = ptr_ff[IDX_W-1:0];
      mem_wdata   = rd_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_wen) begin
               capacity_in = cfg_cap;
            end
            if (req_acc) begin
               op_in      = req_cmd;
               value_in   = req_value;
               pos_in     = CNT_W'(req_pos_w);
               element_in = '0;
               eidx_in    = '0;
               last_in    = 1'b1;
               status_in  = STS_OK;
               case (req_cmd)
                  CMD_APPEND: begin
                     capacity_in = cap_grow;
                     if (int'(count_ff) >= DEPTH || count_ff >= cap_grow) begin
                        status_in = STS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[IDX_W-1:0];
                        mem_wdata = req_value;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_INSERT: begin
                     ptr_in = count_ff;
                     if (req_pos_w > count_w) begin
                        status_in = STS_BADIDX;
                     end else if (count_ff >= capacity_ff || int'(count_ff) >= DEPTH) begin
                        status_in = STS_FULL;
                     end
                  end
                  CMD_REMOVE: begin
                     ptr_in = CNT_W'(req_pos_w);
                     if (count_ff == '0) begin
                        status_in = STS_EMPTY;
                     end else if (req_pos_w >= count_w) begin
                        status_in = STS_BADIDX;
                     end
                  end
                  default: begin
                     ptr_in = '0;
                     if (count_ff == '0) begin
                        status_in = STS_EMPTY;
                     end
                  end
               endcase
            end
         end
         ST_INS_STEP: begin
            if (ptr_ff == pos_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff[IDX_W-1:0];
               mem_wdata = value_ff;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         ST_INS_WR: begin
            // entry ptr-1 moves up into ptr
            mem_we = 1'b1;
            ptr_in = ptr_dec;
         end
         ST_REM_STEP: begin
            if (ptr_inc >= count_ff) begin
               count_in = cnt_dec;
               if (cnt_dec == cap_half) begin
                  capacity_in = (cap_half == '0) ? CNT_W'(1) : cap_half;
               end
            end
         end
         ST_REM_WR: begin
            // entry ptr+1 moves down into ptr
            mem_we = 1'b1;
            ptr_in = ptr_inc;
         end
         ST_SHOW_LD: begin
            element_in = rd_data_ff;
            eidx_in    = POS_W'(ptr_ff);
            last_in    = (ptr_inc == count_ff);
            status_in  = STS_OK;
         end
         ST_RESP: begin
            if (rsp_tready && op_ff == CMD_SHOW && !last_ff) begin
               ptr_in = ptr_inc;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         capacity_ff <= clamp_cap(CAP_CFG_W'(INIT_CAP));
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         capacity_ff <= capacity_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      ptr_ff     <= ptr_in;
      pos_ff     <= pos_in;
      value_ff   <= value_in;
      status_ff  <= status_in;
      element_ff <= element_in;
      eidx_ff    <= eidx_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), SIZE_W'(capacity_ff), SIZE_W'(count_ff),
                        eidx_ff, element_ff, status_ff};

   `GAI_ASSERT_ALWAYS(a_count_le_cap, clock, reset, count_ff <= capacity_ff)
   `GAI_ASSERT_ALWAYS(a_cap_nonzero, clock, reset, capacity_ff != '0 && int'(capacity_ff) <= DEPTH)
   `GAI_ASSERT_IMPLY(a_no_accept_while_busy, clock, reset, rsp_tvalid, !req_tready)
   `GAI_ASSERT_IMPLY(a_shift_in_range, clock, reset, state_ff == ST_INS_WR || state_ff == ST_REM_WR, ptr_ff < count_ff || (state_ff == ST_INS_WR && ptr_ff == count_ff))

endmodule

// ----- tb/growable_array_checker.sv -----
// Checker for the growable array core: watches the request, response and
// capacity-register ports, predicts every response and compares it.
// Depends on gai_pkg for sizes and the command and status codes.
module growable_array_checker
   import gai_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  logic [CAP_CFG_W-1:0]  csr_wdata,
   output int                    error_count,
   output int                    pending_results
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      status_type               status;
      logic signed [ELEM_W-1:0] element;
      logic [POS_W-1:0]         element_index;
      logic [SIZE_W-1:0]        size_now;
      logic [SIZE_W-1:0]        capacity_now;
      logic                     last;
   } array_result_t;

   logic signed [ELEM_W-1:0] stored [DEPTH];
   int fill_count = 0;
   int logical_cap = INIT_CAP;
   int mismatches = 0;
   array_result_t expected_results[$];

   function automatic int bound_capacity(input int c);
      int r;
      r = c;
      if (c < 1) begin
         r = 1;
      end else if (c > DEPTH) begin
         r = DEPTH;
      end
      return r;
   endfunction

   task automatic push_result(input status_type s, input logic signed [ELEM_W-1:0] e,
                              input int idx, input logic last);
      array_result_t r;
      r.status        = s;
      r.element       = e;
      r.element_index = POS_W'(idx);
      r.size_now      = SIZE_W'(fill_count);
      r.capacity_now  = SIZE_W'(logical_cap);
      r.last          = last;
      expected_results.push_back(r);
   endtask

   // Update the array model for one accepted request and queue its responses
   task automatic predict_request(input cmd_type op, input logic signed [ELEM_W-1:0] value,
                                  input int pos);
      int i;
      case (op)
         CMD_APPEND: begin
            // grow before deciding whether the append fits
            if (fill_count >= logical_cap) begin
               logical_cap = (2 * logical_cap > DEPTH) ? DEPTH : 2 * logical_cap;
            end
            if (fill_count >= DEPTH || fill_count >= logical_cap) begin
               push_result(STS_FULL, '0, 0, 1'b1);
            end else begin
               stored[fill_count] = value;
               fill_count++;
               push_result(STS_OK, '0, 0, 1'b1);
            end
         end
         CMD_INSERT: begin
            if (pos > fill_count) begin
               push_result(STS_BADIDX, '0, 0, 1'b1);
            end else if (fill_count >= logical_cap || fill_count >= DEPTH) begin
               push_result(STS_FULL, '0, 0, 1'b1);
            end else begin
               for (i = fill_count; i > pos; i--) begin
                  stored[i] = stored[i-1];
               end
               stored[pos] = value;
               fill_count++;
               push_result(STS_OK, '0, 0, 1'b1);
            end
         end
         CMD_REMOVE: begin
            if (fill_count == 0) begin
               push_result(STS_EMPTY, '0, 0, 1'b1);
            end else if (pos >= fill_count) begin
               push_result(STS_BADIDX, '0, 0, 1'b1);
            end else begin
               for (i = pos; i + 1 < fill_count; i++) begin
                  stored[i] = stored[i+1];
               end
               fill_count--;
               // shrink when half empty, never below one
               if (fill_count == logical_cap / 2) begin
                  logical_cap = (logical_cap / 2 < 1) ? 1 : logical_cap / 2;
               end
               push_result(STS_OK, '0, 0, 1'b1);
            end
         end
         default: begin
            if (fill_count == 0) begin
               push_result(STS_EMPTY, '0, 0, 1'b1);
            end else begin
               for (i = 0; i < fill_count; i++) begin
                  push_result(STS_OK, stored[i], i, (i + 1 == fill_count));
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : monitor
      array_result_t got;
      array_result_t want;
      if (reset) begin
         fill_count  = 0;
         logical_cap = bound_capacity(INIT_CAP);
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status        = status_type'(rsp_tdata[1:0]);
            got.element       = rsp_tdata[33:2];
            got.element_index = rsp_tdata[39:34];
            got.size_now      = rsp_tdata[46:40];
            got.capacity_now  = rsp_tdata[53:47];
            got.last          = rsp_tlast;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected response: status %0d element %0d index %0d size %0d cap %0d",
                           got.status, got.element, got.element_index, got.size_now,
                           got.capacity_now);
               end
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.element !== want.element ||
                   got.element_index !== want.element_index ||
                   got.size_now !== want.size_now ||
                   got.capacity_now !== want.capacity_now || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("response mismatch (expected/actual): status %0d/%0d",
                              want.status, got.status,
                              " element %0d/%0d index %0d/%0d",
                              want.element, got.element, want.element_index,
                              got.element_index,
                              " size %0d/%0d cap %0d/%0d last %0d/%0d",
                              want.size_now, got.size_now, want.capacity_now,
                              got.capacity_now, want.last, got.last);
                  end
               end
            end
         end
         if (csr_wen) begin
            logical_cap = bound_capacity(int'(csr_wdata));
            if (logical_cap < fill_count) begin
               logical_cap = fill_count;
            end
         end
         if (req_tvalid && req_tready) begin
            predict_request(cmd_type'(req_tuser), req_tdata[31:0], int'(req_tdata[37:32]));
         end
      end
      error_count     <= mismatches;
      pending_results <= expected_results.size();
   end

endmodule

// ----- tb/tb_growable_array_insert_remove_core.sv -----
// Top of the growable array testbench: clock, reset, directed and random
// requests, capacity writes and the verdict. Depends on gai_pkg, the core
// and growable_array_checker.
module tb_growable_array_insert_remove_core;
   import gai_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int STALL_LIMIT = 4000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wen    = 1'b0;
   logic [CAP_CFG_W-1:0]  csr_wdata  = '0;

   int error_count;
   int pending_results;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;
   bit grow_bias      = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   growable_array_insert_remove_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   growable_array_checker array_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("tb_growable_array_insert_remove_core: done, errors");
         $finish;
      end
   end

   task automatic send_request(input cmd_type op, input logic [31:0] value,
                               input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, pos, value};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold until every predicted response has come back
   task automatic drain_results;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_CFG_W-1:0] cap);
      csr_wen   <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_wen   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_request;
      int roll;
      cmd_type op;
      logic [31:0] value;
      logic [POS_W-1:0] pos;
      roll = $urandom_range(99);
      if (grow_bias) begin
         op = (roll < 45) ? CMD_APPEND : (roll < 70) ? CMD_INSERT :
              (roll < 88) ? CMD_REMOVE : CMD_SHOW;
      end else begin
         op = (roll < 20) ? CMD_APPEND : (roll < 40) ? CMD_INSERT :
              (roll < 85) ? CMD_REMOVE : CMD_SHOW;
      end
      value = $urandom;
      if ($urandom_range(9) == 0) begin
         value = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      // mostly positions near the live range, a few anywhere in the field
      pos = ($urandom_range(9) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(17));
      send_request(op, value, pos);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int n_requests);
      int i;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (i = 0; i < n_requests; i++) begin
         // alternate filling and draining so the store swings through its sizes
         if (i % 25 == 0) begin
            grow_bias = !grow_bias;
         end
         random_request();
      end
      drain_results();
   endtask

   initial begin
      int i;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store, bad indexes, growth, full at capacity, shrink
      send_request(CMD_SHOW,   32'd0,        6'd0);
      send_request(CMD_REMOVE, 32'd0,        6'd0);
      send_request(CMD_INSERT, 32'd9,        6'd63);
      send_request(CMD_INSERT, 32'h7fff_ffff, 6'd0);
      send_request(CMD_APPEND, 32'h8000_0000, 6'd0);
      send_request(CMD_APPEND, 32'hffff_ffff, 6'd0);
      send_request(CMD_APPEND, 32'd0,        6'd0);
      send_request(CMD_INSERT, 32'h5555_5555, 6'd2);
      send_request(CMD_INSERT, 32'haaaa_aaaa, 6'd5);
      send_request(CMD_INSERT, 32'd1,        6'd0);
      send_request(CMD_REMOVE, 32'd0,        6'd6);
      send_request(CMD_REMOVE, 32'd0,        6'd0);
      send_request(CMD_REMOVE, 32'd0,        6'd4);
      send_request(CMD_REMOVE, 32'd0,        6'd1);
      send_request(CMD_SHOW,   32'd0,        6'd0);
      drain_results();

      // zero capacity below the count, then oversize, then fill to the top
      write_capacity(7'd0);
      write_capacity(7'd127);
      for (i = 0; i < 13; i++) begin
         send_request(CMD_APPEND, $urandom, 6'd0);
      end
      send_request(CMD_APPEND, 32'd7,  6'd0);
      send_request(CMD_INSERT, 32'd7,  6'd16);
      send_request(CMD_SHOW,   32'd0,  6'd0);
      drain_results();
      write_capacity(7'd64);

      run_phase(0, 0, 90);
      write_capacity(7'd1);
      run_phase(79, 0, 90);
      write_capacity(CAP_CFG_W'($urandom_range(2, 15)));
      run_phase(0, 79, 90);
      write_capacity(7'd16);
      run_phase(30, 30, 90);
      write_capacity(7'd5);
      run_phase(0, 0, 60);

      repeat (32) @(posedge clock);
      if (error_count == 0 && pending_results == 0) begin
         $display("tb_growable_array_insert_remove_core: done, clean");
      end else begin
         $display("tb_growable_array_insert_remove_core: done, errors");
      end
      $finish;
   end

endmodule
